>>> rtl/skt_pkg.sv
// Package with the types and constants shared by the sorted key table modules.
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

    localparam int KEY_W      = 32;
    localparam int DATA_W     = 64;
    localparam int POS_W      = 8;
    localparam int COUNT_W    = 9;
    localparam int STATUS_W   = 2;
    localparam int GROUP_SIZE = 16;

    localparam logic ACT_SEARCH = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DUP  = 2'd2;

    typedef struct packed {
        logic              action;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data_a;
        logic [DATA_W-1:0] data_b;
        logic [DATA_W-1:0] data_c;
    } t_in_item;

    typedef struct packed {
        logic                found;
        logic [POS_W-1:0]    position;
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   hit_a;
        logic [DATA_W-1:0]   hit_b;
        logic [DATA_W-1:0]   hit_c;
        logic [COUNT_W-1:0]  count;
    } t_result;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data_a;
        logic [DATA_W-1:0] data_b;
        logic [DATA_W-1:0] data_c;
    } t_entry;

    typedef struct packed {
        logic lt;
        logic eq;
        logic sel;
    } t_cell_flags;

endpackage

`default_nettype wire

>>> rtl/skt_cell.sv
// One table cell: holds one entry, compares it with the item key and shifts on insert.
`timescale 1ns / 1ps
`default_nettype none

module skt_cell
    import skt_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 9
) (
    input  wire                     i_clk,
    input  wire                     i_cmp_en,
    input  wire  [KEY_W-1:0]        i_key,
    input  wire  [CW-1:0]           i_count,
    input  wire                     i_shift_en,
    input  t_entry                  i_new,
    input  t_entry                  i_prev,
    input  wire                     i_prev_lt,
    output t_entry                  o_entry,
    output t_cell_flags             o_flags
);

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    t_entry r_entry;
    logic   r_lt;
    logic   r_eq;
    logic   w_live;
    logic   w_sel;

    assign w_live = IDX_C < i_count;
    assign w_sel  = !r_lt && i_prev_lt;

    always_ff @(posedge i_clk) begin
        if (i_cmp_en) begin
            r_lt <= w_live && (r_entry.key < i_key);
            r_eq <= w_live && (r_entry.key == i_key);
        end
        if (i_shift_en && !r_lt) begin
            r_entry <= w_sel ? i_new : i_prev;
        end
    end

    assign o_entry     = r_entry;
    assign o_flags.lt  = r_lt;
    assign o_flags.eq  = r_eq;
    assign o_flags.sel = w_sel;

endmodule

`default_nettype wire

>>> rtl/skt_group.sv
// Registered reduction of the match flags, position and entry over a group of cells.
`timescale 1ns / 1ps
`default_nettype none

module skt_group
    import skt_pkg::*;
#(
    parameter int BASE = 0,
    parameter int LEN  = 16,
    parameter int IW   = 8
) (
    input  wire                     i_clk,
    input  wire                     i_en,
    input  t_cell_flags             i_flags [LEN],
    input  t_entry                  i_entries [LEN],
    output logic                    o_eq,
    output logic [IW-1:0]           o_pos,
    output t_entry                  o_entry
);

    logic          r_eq;
    logic [IW-1:0] r_pos;
    t_entry        r_entry;
    logic          n_eq;
    logic [IW-1:0] n_pos;
    t_entry        n_entry;

    always_comb begin
        n_eq    = 1'b0;
        n_pos   = '0;
        n_entry = '0;
        for (int j = 0; j < LEN; j++) begin
            n_eq = n_eq | i_flags[j].eq;
            if (i_flags[j].sel) begin
                n_pos   = n_pos | IW'(BASE + j);
                n_entry = n_entry | i_entries[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_eq    <= n_eq;
            r_pos   <= n_pos;
            r_entry <= n_entry;
        end
    end

    assign o_eq    = r_eq;
    assign o_pos   = r_pos;
    assign o_entry = r_entry;

endmodule

`default_nettype wire

>>> rtl/sorted_key_table_insert_search_unit.sv
// Top level of the sorted key table with search and insert.
//
// A command is transferred at a rising edge where start is high and busy is low.
// The payload carries the action (search or insert), the key and three data words.
// Each command produces exactly one result, shown on o_result for one cycle with
// o_strobe high; the receiver cannot hold it off.
// The table is a row of cells, one per entry, kept in ascending key order.
// After the transfer, the cells compare their keys in state S_CMP, groups of
// up to 16 cells register the reduced flags in S_GRP, and the final merge and
// the decision follow in S_RES; an insert shifts all later cells up by one at the end of S_RES.
// The result strobe goes high when S_RES ends, and busy is low again in that
// cycle, so a new command can be transferred while the result is shown, but
// no new command is taken before then.
// Reset empties the table; entry contents are not cleared and are never read
// before they are written.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table_insert_search_unit
    import skt_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          start,
    output logic         busy,
    input  t_in_item     i_item,
    output logic         o_strobe,
    output t_result      o_result
);

    localparam int IW     = $clog2(CAPACITY);
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int NGROUP = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_GRP,
        S_RES
    } t_state;

    t_state             r_state;
    t_state             n_state;
    t_in_item           r_item;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    t_result            n_result;

    t_cell_flags        w_flags [CAPACITY];
    t_entry             w_entry [CAPACITY];
    t_entry             w_new;

    logic               w_grp_eq    [NGROUP];
    logic [IW-1:0]      w_grp_pos   [NGROUP];
    t_entry             w_grp_entry [NGROUP];

    logic               w_eq_any;
    logic [IW-1:0]      w_pos;
    t_entry             w_hit;
    logic               w_full;
    logic               w_insert_ok;
    logic               w_accept;
    logic [IW+POS_W-1:0] w_pos_ext;
    logic [CW+COUNT_W-1:0] w_count_ext;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    assign w_new.key    = r_item.key;
    assign w_new.data_a = r_item.data_a;
    assign w_new.data_b = r_item.data_b;
    assign w_new.data_c = r_item.data_c;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_first
            skt_cell #(
                .IDX (i),
                .CW  (CW)
            ) u_cell (
                .i_clk      (i_clk),
                .i_cmp_en   (r_state == S_CMP),
                .i_key      (r_item.key),
                .i_count    (r_count),
                .i_shift_en (w_insert_ok),
                .i_new      (w_new),
                .i_prev     (w_new),
                .i_prev_lt  (1'b1),
                .o_entry    (w_entry[i]),
                .o_flags    (w_flags[i])
            );
        end else begin : g_rest
            skt_cell #(
                .IDX (i),
                .CW  (CW)
            ) u_cell (
                .i_clk      (i_clk),
                .i_cmp_en   (r_state == S_CMP),
                .i_key      (r_item.key),
                .i_count    (r_count),
                .i_shift_en (w_insert_ok),
                .i_new      (w_new),
                .i_prev     (w_entry[i-1]),
                .i_prev_lt  (w_flags[i-1].lt),
                .o_entry    (w_entry[i]),
                .o_flags    (w_flags[i])
            );
        end
    end

    for (genvar g = 0; g < NGROUP; g++) begin : g_group
        localparam int BASE = g * GROUP_SIZE;
        localparam int LEN  = (CAPACITY - BASE < GROUP_SIZE) ? (CAPACITY - BASE) : GROUP_SIZE;

        skt_group #(
            .BASE (BASE),
            .LEN  (LEN),
            .IW   (IW)
        ) u_group (
            .i_clk     (i_clk),
            .i_en      (r_state == S_GRP),
            .i_flags   (w_flags[BASE +: LEN]),
            .i_entries (w_entry[BASE +: LEN]),
            .o_eq      (w_grp_eq[g]),
            .o_pos     (w_grp_pos[g]),
            .o_entry   (w_grp_entry[g])
        );
    end

    always_comb begin
        w_eq_any = 1'b0;
        w_pos    = '0;
        w_hit    = '0;
        for (int g = 0; g < NGROUP; g++) begin
            w_eq_any = w_eq_any | w_grp_eq[g];
            w_pos    = w_pos | w_grp_pos[g];
            w_hit    = w_hit | w_grp_entry[g];
        end
    end

    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_insert_ok = (r_state == S_RES) && (r_item.action == ACT_INSERT)
                         && !w_full && !w_eq_any;

    always_comb begin
        n_count     = r_count;
        n_result    = '0;
        n_state     = r_state;
        if (w_insert_ok) begin
            n_count = r_count + 1'b1;
        end
        w_pos_ext   = {{POS_W{1'b0}}, w_pos};
        w_count_ext = {{COUNT_W{1'b0}}, n_count};
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: n_state = S_GRP;
            S_GRP: n_state = S_RES;
            S_RES: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (r_item.action == ACT_SEARCH) begin
            if (w_eq_any) begin
                n_result.found    = 1'b1;
                n_result.position = w_pos_ext[POS_W-1:0];
                n_result.hit_a    = w_hit.data_a;
                n_result.hit_b    = w_hit.data_b;
                n_result.hit_c    = w_hit.data_c;
            end
        end else if (w_full) begin
            n_result.status = STAT_FULL;
        end else if (w_eq_any) begin
            n_result.status = STAT_DUP;
        end else begin
            n_result.found    = 1'b1;
            n_result.position = w_pos_ext[POS_W-1:0];
        end
        n_result.count = w_count_ext[COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            o_strobe <= (r_state == S_RES);
            if (r_state == S_RES) begin
                r_count  <= n_count;
                o_result <= n_result;
            end
            if (w_accept) begin
                r_item <= i_item;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_strobe)
        else $error("result strobe missing four cycles after a transfer");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_result.found && (o_result.status != STAT_OK)))
        else $error("found result carries an error status");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (r_item.action == ACT_INSERT) && o_result.found)
        |-> (r_count == $past(r_count) + 1'b1))
        else $error("successful insert did not grow the table");

    a_busy_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while a command is still at work");

endmodule

`default_nettype wire
